[rtl/pli_pkg.sv]
// ----------------------------------------------------------------------------
// pli_pkg: shared types and codes of the piecewise linear interpolator
// Holds the request and result payloads, the command and status codes,
// the controller states and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package pli_pkg;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_EVAL  = 2'd2;
    // Unused command; it is answered with a zero value and status ok.
    localparam logic [1:0] CMD_RSVD  = 2'd3;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_RANGE = 3'd1;
    localparam logic [2:0] ST_DUP   = 3'd2;
    localparam logic [2:0] ST_FULL  = 3'd3;
    localparam logic [2:0] ST_EMPTY = 3'd4;

    localparam int DIV_STEPS = 32;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] node_x;
        logic signed [31:0] node_y;
        logic signed [31:0] query_x;
    } pli_in_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [2:0]         status;
    } pli_out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_ADD_SCAN,
        S_ADD_SHIFT,
        S_ADD_WRITE,
        S_EVAL_SCAN,
        S_DIFF,
        S_MUL,
        S_DIV_LOAD,
        S_DIV,
        S_FIN,
        S_DONE
    } pli_state_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC,
        IDX_LAST
    } pli_idx_op_t;

    typedef enum logic [1:0] {
        RSEL_ZERO,
        RSEL_Y0,
        RSEL_INTERP
    } pli_rsel_t;

    typedef struct packed {
        logic        load_in;
        pli_idx_op_t idx_op;
        logic        cap_pos;
        logic        cnt_clr;
        logic        cnt_inc;
        logic        wr_shift;
        logic        wr_new;
        logic        cap_lo;
        logic        cap_hi;
        logic        diff_en;
        logic        mul_en;
        logic        div_init;
        logic        div_step;
        logic        res_load;
        pli_rsel_t   res_sel;
        logic [2:0]  res_status;
        logic        out_load;
    } pli_ctrl_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       idx_at_count;
        logic       idx_at_pos;
        logic       idx_zero;
        logic       count_zero;
        logic       count_full;
        logic       key_eq_x;
        logic       key_gt_x;
        logic       key_gt_q;
        logic       x0_eq_q;
        logic       div_last;
    } pli_stat_t;

endpackage

[rtl/pli_datapath.sv]
// ----------------------------------------------------------------------------
// pli_datapath: node memories, scan index, arithmetic and result registers
// Executes the controller's commands; one memory read per cycle, a single
// 32x32 multiplier and a one-bit-per-cycle restoring divider.
// ----------------------------------------------------------------------------
module pli_datapath #(
    parameter int MAX_NODES = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  pli_pkg::pli_in_t   in_payload,
    input  pli_pkg::pli_ctrl_t ctrl,
    output pli_pkg::pli_stat_t stat,
    output pli_pkg::pli_out_t  out_payload
);

    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int AW = $clog2(MAX_NODES);

    pli_pkg::pli_in_t   in_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      pos_reg;
    logic signed [31:0] keys [MAX_NODES];
    logic signed [31:0] vals [MAX_NODES];
    logic signed [31:0] rd_key_reg, rd_val_reg;
    logic signed [31:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic [31:0]        mag_reg, dq_reg, dx_reg;
    logic               neg_reg;
    logic [63:0]        prod_reg;
    logic [31:0]        rem_reg, quo_reg;
    logic [pli_pkg::DCNT_W-1:0] dcnt_reg;
    pli_pkg::pli_out_t  res_reg, out_reg;

    logic [AW-1:0]      rd_addr, wr_addr;
    logic [CW-1:0]      wr_addr_full;
    logic signed [31:0] wr_key, wr_val;
    logic               wr_en;
    logic [32:0]        dy_w, dy_neg_w, dq_w, dx_w;
    logic [32:0]        trial_w, diff_w;
    logic               ge_w;
    logic [31:0]        interp_w;
    logic signed [31:0] res_value_w;

    always_comb begin
        case (ctrl.idx_op)
            pli_pkg::IDX_HOLD: idx_next = idx_reg;
            pli_pkg::IDX_ZERO: idx_next = '0;
            pli_pkg::IDX_INC:  idx_next = idx_reg + CW'(1);
            pli_pkg::IDX_DEC:  idx_next = idx_reg - CW'(1);
            pli_pkg::IDX_LAST: idx_next = count_reg - CW'(1);
            default:           idx_next = idx_reg;
        endcase
    end

    assign rd_addr      = idx_next[AW-1:0];
    assign wr_addr_full = ctrl.wr_shift ? idx_reg + CW'(1) : pos_reg;
    assign wr_addr      = wr_addr_full[AW-1:0];
    assign wr_en        = ctrl.wr_shift | ctrl.wr_new;
    assign wr_key       = ctrl.wr_shift ? rd_key_reg : in_reg.node_x;
    assign wr_val       = ctrl.wr_shift ? rd_val_reg : in_reg.node_y;

    // The read port follows the next index, so the read data always
    // belongs to the current index.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            keys[wr_addr] <= wr_key;
            vals[wr_addr] <= wr_val;
        end
        rd_key_reg <= keys[rd_addr];
        rd_val_reg <= vals[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            idx_reg   <= '0;
        end else begin
            idx_reg <= idx_next;
            if (ctrl.cnt_clr) begin
                count_reg <= '0;
            end else if (ctrl.cnt_inc) begin
                count_reg <= count_reg + CW'(1);
            end
        end
    end

    assign dy_w     = {y1_reg[31], y1_reg} - {y0_reg[31], y0_reg};
    assign dy_neg_w = -dy_w;
    assign dq_w     = {in_reg.query_x[31], in_reg.query_x} - {x0_reg[31], x0_reg};
    assign dx_w     = {x1_reg[31], x1_reg} - {x0_reg[31], x0_reg};

    assign trial_w = {rem_reg, quo_reg[31]};
    assign diff_w  = trial_w - {1'b0, dx_reg};
    assign ge_w    = trial_w >= {1'b0, dx_reg};

    assign interp_w = neg_reg ? y0_reg - quo_reg : y0_reg + quo_reg;

    always_comb begin
        case (ctrl.res_sel)
            pli_pkg::RSEL_ZERO:   res_value_w = '0;
            pli_pkg::RSEL_Y0:     res_value_w = y0_reg;
            pli_pkg::RSEL_INTERP: res_value_w = interp_w;
            default:              res_value_w = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_in) begin
            in_reg <= in_payload;
        end
        if (ctrl.cap_pos) begin
            pos_reg <= idx_reg;
        end
        if (ctrl.cap_lo) begin
            x0_reg <= rd_key_reg;
            y0_reg <= rd_val_reg;
        end
        if (ctrl.cap_hi) begin
            x1_reg <= rd_key_reg;
            y1_reg <= rd_val_reg;
        end
        if (ctrl.diff_en) begin
            neg_reg <= dy_w[32];
            mag_reg <= dy_w[32] ? dy_neg_w[31:0] : dy_w[31:0];
            dq_reg  <= dq_w[31:0];
            dx_reg  <= dx_w[31:0];
        end
        if (ctrl.mul_en) begin
            prod_reg <= 64'(mag_reg) * 64'(dq_reg);
        end
        if (ctrl.div_init) begin
            rem_reg  <= prod_reg[63:32];
            quo_reg  <= prod_reg[31:0];
            dcnt_reg <= '0;
        end else if (ctrl.div_step) begin
            rem_reg  <= ge_w ? diff_w[31:0] : trial_w[31:0];
            quo_reg  <= {quo_reg[30:0], ge_w};
            dcnt_reg <= dcnt_reg + pli_pkg::DCNT_W'(1);
        end
        if (ctrl.res_load) begin
            res_reg.value  <= res_value_w;
            res_reg.status <= ctrl.res_status;
        end
        if (ctrl.out_load) begin
            out_reg <= res_reg;
        end
    end

    assign out_payload = out_reg;

    assign stat.cmd          = in_reg.cmd;
    assign stat.idx_at_count = idx_reg == count_reg;
    assign stat.idx_at_pos   = idx_reg == pos_reg;
    assign stat.idx_zero     = idx_reg == '0;
    assign stat.count_zero   = count_reg == '0;
    assign stat.count_full   = count_reg == CW'(MAX_NODES);
    assign stat.key_eq_x     = rd_key_reg == in_reg.node_x;
    assign stat.key_gt_x     = rd_key_reg > in_reg.node_x;
    assign stat.key_gt_q     = rd_key_reg > in_reg.query_x;
    assign stat.x0_eq_q      = x0_reg == in_reg.query_x;
    assign stat.div_last     = dcnt_reg == pli_pkg::DCNT_W'(pli_pkg::DIV_STEPS - 1);

endmodule

[rtl/pli_ctrl.sv]
// ----------------------------------------------------------------------------
// pli_ctrl: sequencing state machine of the piecewise linear interpolator
// Walks each request through table scan, insertion shift or the
// interpolation arithmetic, and owns both channel handshakes.
// ----------------------------------------------------------------------------
module pli_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  pli_pkg::pli_stat_t stat,
    output pli_pkg::pli_ctrl_t ctrl
);

    pli_pkg::pli_state_t state_reg, state_next;
    logic                m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pli_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign s_ready = state_reg == pli_pkg::S_IDLE;

    always_comb begin
        state_next      = state_reg;
        m_valid_next    = m_valid_reg & ~m_ready;
        ctrl            = '0;
        ctrl.idx_op     = pli_pkg::IDX_HOLD;
        ctrl.res_sel    = pli_pkg::RSEL_ZERO;
        ctrl.res_status = pli_pkg::ST_OK;

        case (state_reg)
            pli_pkg::S_IDLE: begin
                if (s_valid) begin
                    ctrl.load_in = 1'b1;
                    ctrl.idx_op  = pli_pkg::IDX_ZERO;
                    state_next   = pli_pkg::S_DISPATCH;
                end
            end
            pli_pkg::S_DISPATCH: begin
                ctrl.res_load = 1'b1;
                case (stat.cmd)
                    pli_pkg::CMD_CLEAR: begin
                        ctrl.cnt_clr = 1'b1;
                        state_next   = pli_pkg::S_DONE;
                    end
                    pli_pkg::CMD_ADD: begin
                        state_next = pli_pkg::S_ADD_SCAN;
                    end
                    pli_pkg::CMD_EVAL: begin
                        if (stat.count_zero) begin
                            ctrl.res_status = pli_pkg::ST_EMPTY;
                            state_next      = pli_pkg::S_DONE;
                        end else begin
                            state_next = pli_pkg::S_EVAL_SCAN;
                        end
                    end
                    default: begin
                        state_next = pli_pkg::S_DONE;
                    end
                endcase
            end
            pli_pkg::S_ADD_SCAN: begin
                if (!stat.idx_at_count && stat.key_eq_x) begin
                    ctrl.res_load   = 1'b1;
                    ctrl.res_status = pli_pkg::ST_DUP;
                    state_next      = pli_pkg::S_DONE;
                end else if (stat.idx_at_count || stat.key_gt_x) begin
                    // Keys are sorted, so nothing past here can match.
                    if (stat.count_full) begin
                        ctrl.res_load   = 1'b1;
                        ctrl.res_status = pli_pkg::ST_FULL;
                        state_next      = pli_pkg::S_DONE;
                    end else begin
                        ctrl.cap_pos = 1'b1;
                        if (stat.idx_at_count) begin
                            state_next = pli_pkg::S_ADD_WRITE;
                        end else begin
                            ctrl.idx_op = pli_pkg::IDX_LAST;
                            state_next  = pli_pkg::S_ADD_SHIFT;
                        end
                    end
                end else begin
                    ctrl.idx_op = pli_pkg::IDX_INC;
                end
            end
            pli_pkg::S_ADD_SHIFT: begin
                ctrl.wr_shift = 1'b1;
                if (stat.idx_at_pos) begin
                    state_next = pli_pkg::S_ADD_WRITE;
                end else begin
                    ctrl.idx_op = pli_pkg::IDX_DEC;
                end
            end
            pli_pkg::S_ADD_WRITE: begin
                ctrl.wr_new   = 1'b1;
                ctrl.cnt_inc  = 1'b1;
                ctrl.res_load = 1'b1;
                state_next    = pli_pkg::S_DONE;
            end
            pli_pkg::S_EVAL_SCAN: begin
                if (stat.idx_at_count) begin
                    ctrl.res_load = 1'b1;
                    if (stat.x0_eq_q) begin
                        ctrl.res_sel = pli_pkg::RSEL_Y0;
                    end else begin
                        ctrl.res_status = pli_pkg::ST_RANGE;
                    end
                    state_next = pli_pkg::S_DONE;
                end else if (stat.key_gt_q) begin
                    if (stat.idx_zero) begin
                        ctrl.res_load   = 1'b1;
                        ctrl.res_status = pli_pkg::ST_RANGE;
                        state_next      = pli_pkg::S_DONE;
                    end else begin
                        ctrl.cap_hi = 1'b1;
                        state_next  = pli_pkg::S_DIFF;
                    end
                end else begin
                    ctrl.cap_lo = 1'b1;
                    ctrl.idx_op = pli_pkg::IDX_INC;
                end
            end
            pli_pkg::S_DIFF: begin
                ctrl.diff_en = 1'b1;
                state_next   = pli_pkg::S_MUL;
            end
            pli_pkg::S_MUL: begin
                ctrl.mul_en = 1'b1;
                state_next  = pli_pkg::S_DIV_LOAD;
            end
            pli_pkg::S_DIV_LOAD: begin
                ctrl.div_init = 1'b1;
                state_next    = pli_pkg::S_DIV;
            end
            pli_pkg::S_DIV: begin
                ctrl.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = pli_pkg::S_FIN;
                end
            end
            pli_pkg::S_FIN: begin
                ctrl.res_load = 1'b1;
                ctrl.res_sel  = pli_pkg::RSEL_INTERP;
                state_next    = pli_pkg::S_DONE;
            end
            pli_pkg::S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    ctrl.out_load = 1'b1;
                    m_valid_next  = 1'b1;
                    state_next    = pli_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = pli_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[rtl/piecewise_linear_interpolator_core.sv]
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_core: sorted node table with interpolation
// A request carries a command: clear the table, add a node (x, y), or
// evaluate the polyline at query_x. Every request yields one result with
// a Q16.16 value and a status code.
//
// Both channels use valid/ready; s_payload holds the request and
// m_payload the result. One request is processed at a time. A clear, an
// unused command or an evaluation of an empty table goes from dispatch
// straight to the result. An add scans the table at one entry per cycle
// up to its insertion point and then shifts the larger entries up by one
// per cycle; scan and shift together touch N + 1 entries for N nodes. An
// evaluation scans until it passes the query, then forms the differences,
// the 32x32 product, the quotient in the bit-serial divider and then the
// interpolated value.
// The result sits in an output register, so a new request is accepted
// while an earlier result still waits; if the receiver stalls, the next
// result waits in the result register until the output register frees up.
// After reset the table is empty; no clearing pass is needed.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator_core #(
    parameter int MAX_NODES = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pli_pkg::pli_in_t  s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output pli_pkg::pli_out_t m_payload
);

    // Commands from the controller and status flags back from the datapath.
    pli_pkg::pli_ctrl_t ctrl;
    pli_pkg::pli_stat_t stat;

    pli_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    // The datapath owns the node memories, the node count and the
    // arithmetic; its size follows the table depth.
    pli_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_payload  (s_payload),
        .ctrl        (ctrl),
        .stat        (stat),
        .out_payload (m_payload)
    );

endmodule
